>>> rtl/xcfe_pkg.sv
// ----------------------------------------------------------------------------
// xcfe_pkg
// Types, constants and command/status bundles of the frame extractor.
// ----------------------------------------------------------------------------
package xcfe_pkg;

    localparam int BUF_DEPTH  = 64;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int OVERHEAD   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0]       RST_START_BYTE = 8'd170;
    localparam logic [7:0]       RST_END_BYTE   = 8'd85;
    localparam logic [6:0]       RST_MIN_LEN    = 7'd6;
    localparam logic [6:0]       RST_MAX_LEN    = 7'd64;
    localparam logic [7:0]       RST_POLL_LIMIT = 8'd250;

    localparam logic [0:0] OP_APPEND = 1'b0;
    localparam logic [0:0] OP_POLL   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE = 3'd0,
        CFG_END_BYTE   = 3'd1,
        CFG_MIN_LEN    = 3'd2,
        CFG_MAX_LEN    = 3'd3,
        CFG_POLL_LIMIT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [0:0] op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_of_frame;
        logic       empty_payload;
        logic [6:0] frame_length;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HDR,
        ST_HDR_WAIT,
        ST_EVAL,
        ST_SUM,
        ST_CK,
        ST_CE,
        ST_PAY
    } t_state;

    typedef struct packed {
        logic append;
        logic off_clr;
        logic off_four;
        logic rd;
        logic hdr_cap;
        logic sum_clr;
        logic sum_acc;
        logic ck_cap;
        logic drop_one;
        logic drop_len;
        logic stall_inc;
        logic emit;
        logic emit_last;
        logic emit_empty;
    } t_cmd;

    typedef struct packed {
        logic cnt_ge_lo;
        logic hdr_ok;
        logic frame_short;
        logic stall_hit;
        logic at_trailer;
        logic frame_ok;
        logic len_is_min;
    } t_status;

endpackage

>>> rtl/xor_checked_frame_extractor.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_extractor
// Length-prefixed frame deframer with XOR checksum over a 64-byte ring buffer.
// ----------------------------------------------------------------------------
// An append is taken in its accept cycle and never raises busy. A poll holds busy
// while it steps through each candidate start (check, header fetch, length test), plus one
// closing check unless it ends on a stalled frame; a complete frame of length L adds
// the checksum and trailer steps and, with a payload, emits its bytes one byte a cycle.
// Header, checksum, trailer and payload bytes all go through the single read port.
// Results cannot be stalled; synchronous active-low reset empties the buffer.
module xor_checked_frame_extractor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  xcfe_pkg::t_in_item                  i_item,
    output logic                                o_valid,
    output xcfe_pkg::t_out_item                 o_res,
    input  logic                                i_cfg_we,
    input  logic [xcfe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [xcfe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import xcfe_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    ctrl_busy;

    xcfe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_item.op[0]),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy)
    );

    xcfe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_item.data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

    assign busy = ctrl_busy;

endmodule

>>> rtl/xcfe_ctrl.sv
// ----------------------------------------------------------------------------
// xcfe_ctrl
// Scan sequencer: walks header, checksum, trailer and payload of each frame.
// ----------------------------------------------------------------------------
module xcfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  xcfe_pkg::t_status i_status,
    output xcfe_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import xcfe_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_op == OP_POLL) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_status.cnt_ge_lo ? ST_HDR : ST_IDLE;
            end
            ST_HDR: begin
                if (i_status.at_trailer) n_state = ST_HDR_WAIT;
            end
            ST_HDR_WAIT: n_state = ST_EVAL;
            ST_EVAL: begin
                if (!i_status.hdr_ok) n_state = ST_CHECK;
                else if (!i_status.frame_short) n_state = ST_SUM;
                else if (i_status.stall_hit) n_state = ST_IDLE;
                else n_state = ST_CHECK;
            end
            ST_SUM: begin
                if (i_status.at_trailer) n_state = ST_CK;
            end
            ST_CK: n_state = ST_CE;
            ST_CE: begin
                if (i_status.frame_ok && !i_status.len_is_min) n_state = ST_PAY;
                else n_state = ST_CHECK;
            end
            ST_PAY: begin
                if (i_status.at_trailer) n_state = ST_CHECK;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.append = i_start && i_op == OP_APPEND;
            end
            ST_CHECK: begin
                o_cmd.off_clr = 1'b1;
            end
            ST_HDR: begin
                // In this state at_trailer flags the last header offset.
                o_cmd.rd      = 1'b1;
                o_cmd.hdr_cap = 1'b1;
            end
            ST_HDR_WAIT: begin
                o_cmd.hdr_cap = 1'b1;
            end
            ST_EVAL: begin
                o_cmd.off_clr = 1'b1;
                o_cmd.sum_clr = 1'b1;
                if (!i_status.hdr_ok) begin
                    o_cmd.drop_one = 1'b1;
                end else if (i_status.frame_short) begin
                    if (i_status.stall_hit) o_cmd.stall_inc = 1'b1;
                    else o_cmd.drop_one = 1'b1;
                end
            end
            ST_SUM: begin
                o_cmd.rd      = 1'b1;
                o_cmd.sum_acc = 1'b1;
            end
            ST_CK: begin
                o_cmd.rd     = 1'b1;
                o_cmd.ck_cap = 1'b1;
            end
            ST_CE: begin
                o_cmd.off_four = 1'b1;
                if (!i_status.frame_ok) begin
                    o_cmd.drop_one = 1'b1;
                end else if (i_status.len_is_min) begin
                    o_cmd.emit_empty = 1'b1;
                    o_cmd.drop_len   = 1'b1;
                end
            end
            ST_PAY: begin
                o_cmd.emit = 1'b1;
                if (i_status.at_trailer) begin
                    o_cmd.emit_last = 1'b1;
                    o_cmd.drop_len  = 1'b1;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> rtl/xcfe_dp.sv
// ----------------------------------------------------------------------------
// xcfe_dp
// Ring buffer, pointers, configuration, checksum and result register.
// ----------------------------------------------------------------------------
module xcfe_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  xcfe_pkg::t_cmd                      i_cmd,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_cfg_we,
    input  logic [xcfe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [xcfe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output xcfe_pkg::t_status                   o_status,
    output logic                                o_valid,
    output xcfe_pkg::t_out_item                 o_res
);
    import xcfe_pkg::*;

    logic [7:0]        r_mem [BUF_DEPTH];
    logic [7:0]        r_rdata;
    logic              r_dv;
    logic [ADDR_W-1:0] r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic [7:0]        r_stall;
    logic [CNT_W-1:0]  r_off;
    logic [7:0]        r_b0, r_b2, r_b3, r_sum;
    logic              r_ckok;
    logic [6:0]        r_len;
    logic [7:0]        r_start, r_end, r_limit;
    logic [6:0]        r_min, r_max;
    logic              r_valid;
    t_out_item         r_res;

    logic [6:0]        lo, hi;
    logic [16:0]       len_full;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [7:0]        stall_nx;
    logic [CNT_W-1:0]  trail_off;

    assign lo        = (r_min < 7'(OVERHEAD)) ? 7'(OVERHEAD) : r_min;
    assign hi        = (r_max > 7'(BUF_DEPTH)) ? 7'(BUF_DEPTH) : r_max;
    assign len_full  = {1'b0, r_b2, r_b3} + 17'(OVERHEAD);
    assign raddr     = r_rp + r_off[ADDR_W-1:0];
    assign waddr     = r_rp + r_cnt[ADDR_W-1:0];
    assign stall_nx  = r_stall + 8'd1;
    assign trail_off = CNT_W'(r_len) - CNT_W'(2);

    always_comb begin
        o_status.cnt_ge_lo   = 7'(r_cnt) >= lo;
        o_status.hdr_ok      = r_b0 == r_start && len_full >= 17'(lo)
                               && len_full <= 17'(hi);
        o_status.frame_short = 17'(r_cnt) < len_full;
        o_status.stall_hit   = stall_nx < r_limit;
        // During the header fetch this marks offset 3, otherwise the checksum byte.
        o_status.at_trailer  = (i_cmd.hdr_cap) ? (r_off == CNT_W'(3))
                                               : (r_off == trail_off);
        o_status.frame_ok    = r_ckok && r_rdata == r_end;
        o_status.len_is_min  = r_len == 7'(OVERHEAD);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && r_cnt < CNT_W'(BUF_DEPTH)) begin
            r_mem[waddr] <= i_data_byte;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_cnt   <= '0;
            r_stall <= '0;
            r_dv    <= 1'b0;
            r_valid <= 1'b0;
            r_start <= RST_START_BYTE;
            r_end   <= RST_END_BYTE;
            r_min   <= RST_MIN_LEN;
            r_max   <= RST_MAX_LEN;
            r_limit <= RST_POLL_LIMIT;
        end else begin
            r_dv    <= i_cmd.rd;
            r_valid <= (i_cmd.emit && r_dv) || i_cmd.emit_empty;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START_BYTE: r_start <= i_cfg_data;
                    CFG_END_BYTE:   r_end   <= i_cfg_data;
                    CFG_MIN_LEN:    r_min   <= i_cfg_data[6:0];
                    CFG_MAX_LEN:    r_max   <= i_cfg_data[6:0];
                    CFG_POLL_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.append && r_cnt < CNT_W'(BUF_DEPTH)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.drop_one) begin
                r_rp    <= r_rp + ADDR_W'(1);
                r_cnt   <= r_cnt - CNT_W'(1);
                r_stall <= '0;
            end else if (i_cmd.drop_len) begin
                r_rp    <= r_rp + r_len[ADDR_W-1:0];
                r_cnt   <= r_cnt - CNT_W'(r_len);
                r_stall <= '0;
            end else if (i_cmd.stall_inc) begin
                r_stall <= stall_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.off_clr) begin
            r_off <= '0;
        end else if (i_cmd.off_four) begin
            r_off <= CNT_W'(4);
        end else if (i_cmd.rd) begin
            r_off <= r_off + CNT_W'(1);
        end
        // Read data comes from a registered read, so the offset is one ahead of r_rdata.
        if (i_cmd.hdr_cap && r_dv) begin
            if (r_off == CNT_W'(1)) r_b0 <= r_rdata;
            if (r_off == CNT_W'(3)) r_b2 <= r_rdata;
            if (r_off == CNT_W'(4)) r_b3 <= r_rdata;
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
            r_len <= len_full[6:0];
        end else if (i_cmd.sum_acc && r_dv) begin
            r_sum <= r_sum ^ r_rdata;
        end
        if (i_cmd.ck_cap) begin
            r_ckok <= r_rdata == r_sum;
        end
        r_res.payload_byte  <= i_cmd.emit_empty ? 8'd0 : r_rdata;
        r_res.last_of_frame <= i_cmd.emit_empty || i_cmd.emit_last;
        r_res.empty_payload <= i_cmd.emit_empty;
        r_res.frame_length  <= r_len;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> rtl/xcfe_checker.sv
// ----------------------------------------------------------------------------
// xcfe_checker
// Port-level checks of the frame extractor, bound to the top level.
// ----------------------------------------------------------------------------
module xcfe_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                busy,
    input logic                o_valid,
    input xcfe_pkg::t_out_item o_res
);
    import xcfe_pkg::*;

    // A result only comes out of a poll that was running in the previous cycle.
    a_valid_in_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result outside a poll");

    // Payload bytes of one frame come out in consecutive cycles.
    a_frame_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.last_of_frame |=> o_valid)
        else $error("gap inside a frame");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.empty_payload |->
            o_res.last_of_frame && o_res.payload_byte == 8'd0)
        else $error("malformed empty-frame result");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.frame_length >= 7'(OVERHEAD)
                 && o_res.frame_length <= 7'(BUF_DEPTH))
        else $error("frame length out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("activity right after reset");

endmodule

bind xor_checked_frame_extractor xcfe_checker u_xcfe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);
